// ----- rtl/shabc_pkg.sv -----
// SHA-256 constants, command bundle type and round functions shared by the compressor modules.
package shabc_pkg;

    localparam int WordW = 32;

    typedef logic [WordW-1:0] word_t;

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Controller to datapath commands
    typedef struct packed {
        logic       store_word;
        logic [3:0] word_index;
        logic       chain_init;
        logic       load_work;
        logic       round_step;
        logic [5:0] round_index;
        logic       chain_add;
        logic       load_digest;
        logic       shift_digest;
    } cmd_t;

    function automatic word_t rotr(word_t x, int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    function automatic word_t small_sigma0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sigma0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- rtl/shabc_ctrl.sv -----
// Sequencer for word intake, the 64 rounds, chaining update and digest output.
module shabc_ctrl
    import shabc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic new_message,
    input  logic end_of_message,
    output logic out_valid,
    input  logic out_stall,
    output logic digest_last,
    output cmd_t cmd
);

    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StRound  = 2'd1;
    localparam logic [1:0] StUpdate = 2'd2;
    localparam logic [1:0] StEmit   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [3:0] word_count_reg, word_count_next;
    logic [5:0] round_reg, round_next;
    logic       end_reg, end_next;
    logic       out_busy_reg, out_busy_next;
    logic [2:0] out_cnt_reg, out_cnt_next;

    logic       in_take;
    logic       out_take;
    logic [3:0] word_idx;

    assign in_stall    = (state_reg != StIdle);
    assign in_take     = in_valid && !in_stall;
    assign out_valid   = out_busy_reg;
    assign out_take    = out_busy_reg && !out_stall;
    assign digest_last = (out_cnt_reg == 3'd7);
    assign word_idx    = new_message ? 4'd0 : word_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        word_count_next = word_count_reg;
        round_next      = round_reg;
        end_next        = end_reg;
        out_busy_next   = out_busy_reg;
        out_cnt_next    = out_cnt_reg;

        cmd              = '0;
        cmd.word_index   = word_idx;
        cmd.round_index  = round_reg;
        cmd.shift_digest = out_take;

        if (out_take)
        begin
            out_cnt_next = out_cnt_reg + 3'd1;
            if (out_cnt_reg == 3'd7)
            begin
                out_busy_next = 1'b0;
            end
        end

        case (state_reg)
            StIdle:
            begin
                if (in_take)
                begin
                    cmd.store_word  = 1'b1;
                    cmd.chain_init  = new_message;
                    word_count_next = word_idx + 4'd1;
                    if (word_idx == 4'd15)
                    begin
                        cmd.load_work = 1'b1;
                        end_next      = end_of_message;
                        round_next    = '0;
                        state_next    = StRound;
                    end
                end
            end
            StRound:
            begin
                cmd.round_step = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = StUpdate;
                end
            end
            StUpdate:
            begin
                cmd.chain_add = 1'b1;
                state_next    = end_reg ? StEmit : StIdle;
            end
            StEmit:
            begin
                // wait until the previous digest has fully drained
                if (!out_busy_reg)
                begin
                    cmd.load_digest = 1'b1;
                    out_busy_next   = 1'b1;
                    out_cnt_next    = '0;
                    state_next      = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= StIdle;
            word_count_reg <= '0;
            round_reg      <= '0;
            end_reg        <= 1'b0;
            out_busy_reg   <= 1'b0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            round_reg      <= round_next;
            end_reg        <= end_next;
            out_busy_reg   <= out_busy_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

endmodule

// ----- rtl/shabc_dpath.sv -----
// Message schedule window, round datapath, chaining value and digest output register.
module shabc_dpath
    import shabc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  word_t message_word,
    output word_t digest_word
);

    word_t w_reg     [16];
    word_t work_reg  [8];
    word_t chain_reg [8];
    word_t dig_reg   [8];

    word_t w_new;
    word_t t1, t2;
    word_t ch, maj;

    // schedule: window holds w[t..t+15], w_reg[0] is the current round word
    assign w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];

    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + RoundK[cmd.round_index]
               + w_reg[0];
    assign t2  = big_sigma0(work_reg[0]) + maj;

    assign digest_word = dig_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.store_word)
        begin
            w_reg[cmd.word_index] <= message_word;
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= InitHash[i];
            end
        end
        else if (cmd.chain_init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= InitHash[i];
            end
        end
        else if (cmd.chain_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_digest)
        begin
            for (int i = 0; i < 8; i++)
            begin
                dig_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.shift_digest)
        begin
            for (int i = 0; i < 7; i++)
            begin
                dig_reg[i] <= dig_reg[i+1];
            end
            dig_reg[7] <= dig_reg[7];
        end
    end

endmodule

// ----- rtl/sha256_block_compressor.sv -----
// Top level of the SHA-256 block compressor: sequencer plus datapath.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_stall  | message_word, new_message, end_of_message
//  output  | out_valid | out_stall | digest_word, digest_last
//
// Words 0..14 of a block are stored into the schedule window. The sixteenth
// word starts the compression: 64 rounds at one round per cycle, then the
// chaining add. A final block then hands the digest to the output register,
// waiting while the previous digest is still draining. The eight digest items
// then leave one per cycle from that output register while out_stall is low,
// and new input items are already taken meanwhile. Reset loads the SHA-256
// initial value into the chaining value and clears the word position. A
// stalled output only holds the input side once a later digest is ready to load.
module sha256_block_compressor
    import shabc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] message_word,
    input  logic        new_message,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic        digest_last
);

    cmd_t cmd;

    // sequencer: word position, round counter, output item count
    shabc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .new_message    (new_message),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_last    (digest_last),
        .cmd            (cmd)
    );

    // schedule window, a..h round registers, chaining value, digest shifter
    shabc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (message_word),
        .digest_word  (digest_word)
    );

endmodule
